// ----- rtl/core/sial_pkg.sv -----
// Shared types and constants for the sorted insert array unit.
// Used by the cell, the response buffer and the top level; depends on nothing.
package sial_pkg;

   localparam int Capacity = 16;
   localparam int ValueW = 32;
   localparam int IndexW = 4;
   localparam int CountW = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_GET    = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic add_en;
      logic rem_en;
      logic occupied;
      logic at_or_after;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [ValueW-1:0] read_value;
      logic [CountW-1:0]        count;
      status_type               status;
   } rsp_type;

endpackage

// ----- rtl/core/sial_cell.sv -----
// One storage cell of the sorted row: holds one entry and shifts with its neighbors.
// Depends on sial_pkg.
module sial_cell (
   input  logic                                clock,
   input  sial_pkg::cell_ctrl_type             ctrl,
   input  logic signed [sial_pkg::ValueW-1:0]  value,
   input  logic signed [sial_pkg::ValueW-1:0]  left_entry,
   input  logic                                left_less,
   input  logic signed [sial_pkg::ValueW-1:0]  right_entry,
   output logic signed [sial_pkg::ValueW-1:0]  entry,
   output logic                                less
);
   import sial_pkg::*;

   logic signed [ValueW-1:0] entry_ff;
   logic signed [ValueW-1:0] entry_in;

   // The new value belongs in front of this entry, or the cell is empty.
   assign less = !ctrl.occupied || (value < entry_ff);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.add_en && less) begin
         entry_in = left_less ? left_entry : value;
      end else if (ctrl.rem_en && ctrl.at_or_after) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/core/sial_rsp_buf.sv -----
// Two-deep response register with a skid stage between the core and the response channel.
// Depends on sial_pkg.
module sial_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  sial_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output sial_pkg::rsp_type out_data
);
   import sial_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    take;

   assign in_stall = skid_valid_ff;
   assign push = in_valid && !skid_valid_ff;
   assign take = main_valid_ff && !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_in = in_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in = in_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data = main_ff;

endmodule

// ----- rtl/core/sorted_insert_array_unit.sv -----
// Top level of the sorted insert array unit: a row of cells that keeps values in order.
// Depends on sial_pkg, sial_cell and sial_rsp_buf.
//
// The unit holds up to 16 signed Q16.16 values in ascending order. Each request adds a
// value at its sorted place (after equal values), reads the entry at an index, or removes
// the entry at an index; the unused fourth mode leaves the store unchanged. Every cell of the
// row compares the new value with its own entry at once and takes its neighbor's entry or
// the new value at the same clock edge, so one request is accepted per cycle while req_stall
// is low. The response is held in an output register; a skid stage lets one more request
// in while a response waits to be taken.
module sorted_insert_array_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic signed [sial_pkg::ValueW-1:0]  req_value,
   input  logic [sial_pkg::IndexW-1:0]         req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sial_pkg::ValueW-1:0]  rsp_read_value,
   output logic [sial_pkg::CountW-1:0]         rsp_count,
   output logic [1:0]                          rsp_status
);
   import sial_pkg::*;

   logic [CountW-1:0]        count_ff, count_in;
   logic                     accept;
   logic                     index_ok;
   logic                     full;
   logic                     add_en, rem_en;
   rsp_type                  rsp_core;
   rsp_type                  rsp_out;
   logic signed [ValueW-1:0] entry [Capacity];
   logic                     less [Capacity];

   assign accept = req_valid && !req_stall;
   assign full = (32'(count_ff) >= Capacity);
   assign index_ok = (32'(req_index) < 32'(count_ff));

   always_comb begin
      add_en = 1'b0;
      rem_en = 1'b0;
      count_in = count_ff;
      rsp_core.read_value = '0;
      rsp_core.status = STATUS_OK;
      case (mode_type'(req_mode))
         MODE_ADD: begin
            if (full) begin
               rsp_core.status = STATUS_FULL;
            end else begin
               add_en = accept;
               count_in = count_ff + CountW'(1);
            end
         end
         MODE_GET: begin
            if (!index_ok) begin
               rsp_core.status = STATUS_BAD_INDEX;
            end else begin
               rsp_core.read_value = entry[req_index];
            end
         end
         MODE_REMOVE: begin
            if (!index_ok) begin
               rsp_core.status = STATUS_BAD_INDEX;
            end else begin
               rem_en = accept;
               count_in = count_ff - CountW'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_core.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      cell_ctrl_type            ctrl;
      logic signed [ValueW-1:0] left_entry;
      logic signed [ValueW-1:0] right_entry;
      logic                     left_less;

      assign ctrl.add_en = add_en;
      assign ctrl.rem_en = rem_en;
      assign ctrl.occupied = (CountW'(i) < count_ff);
      assign ctrl.at_or_after = (i >= 32'(req_index));

      if (i == 0) begin : g_first
         assign left_entry = req_value;
         assign left_less = 1'b0;
      end else begin : g_inner
         assign left_entry = entry[i-1];
         assign left_less = less[i-1];
      end

      if (i == Capacity - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_body
         assign right_entry = entry[i+1];
      end

      sial_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .value      (req_value),
         .left_entry (left_entry),
         .left_less  (left_less),
         .right_entry(right_entry),
         .entry      (entry[i]),
         .less       (less[i])
      );
   end

   sial_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_data  (rsp_core),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (rsp_out)
   );

   assign rsp_read_value = rsp_out.read_value;
   assign rsp_count = rsp_out.count;
   assign rsp_status = rsp_out.status;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= Capacity)
      else $error("stored count exceeds capacity");

   a_full_add_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_type'(req_mode) == MODE_ADD && full) |=> $stable(count_ff))
      else $error("add while full changed the count");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !rsp_valid) |=> (rsp_valid && rsp_count == count_ff))
      else $error("response count does not match stored count");

endmodule

// ----- test/sorted_insert_array_unit_test.sv -----
// Self-checking testbench for the sorted insert array unit: directed and random add, get and
// remove requests against a predictor of the sorted store. Depends on sial_pkg and the RTL.
module sorted_insert_array_unit_test;
   import sial_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RandomRequests = 450;
   localparam int CycleLimit = 100000;

   typedef struct {
      logic [1:0]               mode;
      logic signed [ValueW-1:0] value;
      logic [IndexW-1:0]        index;
   } request_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_mode = MODE_ADD;
   logic signed [ValueW-1:0]   req_value = '0;
   logic [IndexW-1:0]          req_index = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [ValueW-1:0]   rsp_read_value;
   logic [CountW-1:0]          rsp_count;
   logic [1:0]                 rsp_status;

   request_type pending_requests[$];
   rsp_type     expected_results[$];
   request_type next_request;
   rsp_type     oldest_result;

   logic signed [ValueW-1:0] held_values [Capacity];
   int held_count = 0;
   int planned_count = 0;
   int mismatches = 0;
   int responses_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_level = 0;
   int pattern_left = 0;
   int adds_seen = 0, gets_seen = 0, removes_seen = 0, unused_seen = 0;
   int full_seen = 0, bad_index_seen = 0, peak_count = 0;

   sorted_insert_array_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_count(rsp_count),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic plan_request(input logic [1:0] mode, input logic signed [ValueW-1:0] value,
                               input logic [IndexW-1:0] index);
      request_type item;
      item.mode = mode;
      item.value = value;
      item.index = index;
      pending_requests.push_back(item);
      if (mode == MODE_ADD && planned_count < Capacity) begin
         planned_count++;
      end else if (mode == MODE_REMOVE && index < planned_count) begin
         planned_count--;
      end
   endtask

   task automatic predict_sorted_store(input logic [1:0] mode,
                                       input logic signed [ValueW-1:0] value,
                                       input logic [IndexW-1:0] index);
      rsp_type outcome;
      int slot;
      outcome.read_value = '0;
      outcome.status = STATUS_OK;
      case (mode)
         MODE_ADD: begin
            adds_seen++;
            if (held_count >= Capacity) begin
               outcome.status = STATUS_FULL;
               full_seen++;
            end else begin
               slot = held_count;
               while (slot > 0 && value < held_values[slot-1]) begin
                  held_values[slot] = held_values[slot-1];
                  slot--;
               end
               held_values[slot] = value;
               held_count++;
            end
         end
         MODE_GET: begin
            gets_seen++;
            if (index >= held_count) begin
               outcome.status = STATUS_BAD_INDEX;
               bad_index_seen++;
            end else begin
               outcome.read_value = held_values[index];
            end
         end
         MODE_REMOVE: begin
            removes_seen++;
            if (index >= held_count) begin
               outcome.status = STATUS_BAD_INDEX;
               bad_index_seen++;
            end else begin
               for (slot = index; slot + 1 < held_count; slot++) begin
                  held_values[slot] = held_values[slot+1];
               end
               held_count--;
            end
         end
         default: begin
            unused_seen++;
         end
      endcase
      if (held_count > peak_count) begin
         peak_count = held_count;
      end
      outcome.count = CountW'(held_count);
      expected_results.push_back(outcome);
   endtask

   // Driver: offers pending requests in bursts and holds the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_sorted_store(req_mode, req_value, req_index);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 && hold_left == 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_request.mode;
               req_value <= next_request.value;
               req_index <= next_request.index;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a changing stall pattern, plus one long hold-off to back the unit up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && responses_seen >= 150) begin
         hold_done <= 1'b1;
         hold_left <= 60;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left != 1);
      end else begin
         if (pattern_left == 0) begin
            stall_level = $urandom_range(0, 3);
            pattern_left = $urandom_range(10, 60);
         end else begin
            pattern_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_level * 25);
      end
   end

   // Monitor: compares every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen <= responses_seen + 1;
         if (expected_results.size() == 0) begin
            $error("Response arrived with no request outstanding.");
            mismatches++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_read_value !== oldest_result.read_value) begin
               $error("rsp_read_value: expected %0d, got %0d",
                      oldest_result.read_value, rsp_read_value);
               mismatches++;
            end
            if (rsp_count !== oldest_result.count) begin
               $error("rsp_count: expected %0d, got %0d", oldest_result.count, rsp_count);
               mismatches++;
            end
            if (rsp_status !== oldest_result.status) begin
               $error("rsp_status: expected %0d, got %0d", oldest_result.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Run timed out after %0d cycles.", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int i;
      int bias;
      int roll;
      int add_share;
      logic [1:0] mode;
      logic signed [ValueW-1:0] value;
      logic [IndexW-1:0] index;

      // Empty store: bad indexes and the unused mode, then fill past capacity.
      plan_request(MODE_GET, 32'sd0, 4'd0);
      plan_request(MODE_REMOVE, 32'sd0, 4'd15);
      plan_request(MODE_UNUSED, 32'sd7, 4'd3);
      plan_request(MODE_ADD, 32'h8000_0000, 4'd0);
      plan_request(MODE_ADD, 32'h7FFF_FFFF, 4'd0);
      plan_request(MODE_ADD, 32'sd0, 4'd0);
      plan_request(MODE_ADD, 32'sd0, 4'd0);
      plan_request(MODE_ADD, -32'sd1, 4'd0);
      for (i = 5; i < Capacity; i++) begin
         plan_request(MODE_ADD, $urandom, 4'd0);
      end
      plan_request(MODE_ADD, 32'sd65536, 4'd0);
      plan_request(MODE_GET, 32'sd0, 4'd15);
      plan_request(MODE_GET, 32'sd0, 4'd0);
      plan_request(MODE_REMOVE, 32'sd0, 4'd15);
      plan_request(MODE_REMOVE, 32'sd0, 4'd0);
      plan_request(MODE_GET, 32'sd0, 4'd14);

      // Random part: phases that lean toward filling, draining, or a balance.
      bias = 0;
      for (i = 0; i < RandomRequests; i++) begin
         if (i % 60 == 0) begin
            bias = $urandom_range(0, 2);
         end
         add_share = (bias == 0) ? 70 : (bias == 1) ? 20 : 45;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            mode = MODE_UNUSED;
         end else if (roll < add_share) begin
            mode = MODE_ADD;
         end else if (roll < add_share + (100 - add_share) / 2) begin
            mode = MODE_GET;
         end else begin
            mode = MODE_REMOVE;
         end
         case ($urandom_range(0, 9))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2, 3: value = ($signed($urandom_range(0, 7)) - 4) <<< 16;
            default: value = $urandom;
         endcase
         if (planned_count > 0 && $urandom_range(0, 9) != 0) begin
            index = IndexW'($urandom_range(0, planned_count - 1));
         end else begin
            index = IndexW'($urandom_range(0, 15));
         end
         plan_request(mode, value, index);
      end

      @(negedge reset);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Checked %0d responses: %0d adds, %0d gets, %0d removes, %0d unused mode.",
               responses_seen, adds_seen, gets_seen, removes_seen, unused_seen);
      $display("Saw %0d adds while full, %0d bad indexes, and a peak of %0d entries.",
               full_seen, bad_index_seen, peak_count);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
